// ===== rtl/eisbp_pkg.sv =====
package eisbp_pkg;

  localparam int PageSlotsDef      = 8;
  localparam int EntriesPerPageDef = 256;
  localparam int BloomBitsDef      = 8192;
  localparam int HashFuncsDef      = 6;
  localparam int SliceShift        = 10;
  localparam int IdBytes           = 20;

  localparam logic [1:0] StAdded    = 2'd0;
  localparam logic [1:0] StAddFail  = 2'd1;
  localparam logic [1:0] StFound    = 2'd2;
  localparam logic [1:0] StNotFound = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_ADD_BLOOM_RD,
    S_ADD_BLOOM_WAIT,
    S_ADD_BLOOM_WR,
    S_ADD_STORE,
    S_EXPIRE,
    S_LK_PAGE,
    S_LK_BLOOM_RD,
    S_LK_BLOOM_WAIT,
    S_LK_BLOOM_CHK,
    S_LK_ENT_RD,
    S_LK_ENT_WAIT,
    S_LK_ENT_CHK,
    S_DONE
  } eisbp_state_t;

  // masks the identifier bytes at and above the length
  function automatic logic [159:0] eisbp_mask_id(input logic [4:0] len,
                                                 input logic [159:0] id);
    logic [159:0] m;
    m = '0;
    for (int b = 0; b < IdBytes; b++) begin
      if (5'(b) < len) m[b*8 +: 8] = 8'hff;
    end
    return id & m;
  endfunction

endpackage

// ===== rtl/expiring_id_set_bloom_pages.sv =====
// channel | dir | transfer condition     | content
// in_     | in  | in_tvalid & in_tready   | id, hash, kind, time; tuser = mode
// out_    | out | out_tvalid & out_tready | status, slots, kind, expired count
// cfg_    | in  | cfg_valid & cfg_ready   | minimum page lifetime
// steps: an add reads, waits for and writes the bloom word for each hash slice, stores the entry,
// then checks for expiry once per expired page plus a last check, and ends in done;
// opening a page first clears its bloom words, one per cycle; a failed add goes straight to done.
// a lookup scans pages in turn: per hash slice it reads, waits for and checks a bloom word, and in
// pages that pass the bloom test it reads, waits for and checks each entry; one shared bloom port and one entry port.
// reset clears control state only; in_tready stays low until the result transfer is taken.
module expiring_id_set_bloom_pages
  import eisbp_pkg::*;
#(
  parameter int PAGE_SLOTS       = PageSlotsDef,
  parameter int ENTRIES_PER_PAGE = EntriesPerPageDef,
  parameter int HASH_FUNCS       = HashFuncsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // id_length[4:0], id_bytes_low[68:5], id_bytes_mid[132:69], id_bytes_high[164:133],
  // id_hash[228:165], entry_kind[230:229], time_now[294:231], zero fill to 296
  input  logic [295:0] in_tdata,
  input  logic         in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[1:0], page_slot[4:2], entry_slot[12:5], found_kind[14:13],
  // pages_expired[17:15], zero fill to 24
  output logic [23:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);
  localparam int PW   = $clog2(PAGE_SLOTS);
  localparam int CW   = $clog2(PAGE_SLOTS + 1);
  localparam int EW   = $clog2(ENTRIES_PER_PAGE);
  localparam int FW   = $clog2(ENTRIES_PER_PAGE + 1);
  localparam int WPP  = BloomBitsDef / 64;
  localparam int WW   = $clog2(WPP);
  localparam int HW   = (HASH_FUNCS > 1) ? $clog2(HASH_FUNCS) : 1;
  localparam int EAW  = PW + EW;
  localparam int BAW  = PW + WW;

  eisbp_state_t state_r, state_nxt;

  logic [31:0]  page_life_r;
  logic         mode_r;
  logic [4:0]   len_r;
  logic [159:0] id_r;
  logic [63:0]  hash_r, slice_r, now_r;
  logic [1:0]   kind_r;
  logic [HW-1:0] hidx_r;
  logic [WW-1:0] clr_r;
  logic [PW-1:0] oldest_r, newest_r, pg_r;
  logic [CW-1:0] inuse_r, pcnt_r;
  logic [FW-1:0] fill_r [PAGE_SLOTS];
  logic [63:0]  ftime_r [PAGE_SLOTS];
  logic [FW-1:0] ent_r;
  logic [2:0]   expired_r;
  logic         out_valid_r;
  logic [23:0]  out_data_r;

  // bloom port
  logic          b_we;
  logic [BAW-1:0] b_waddr, b_raddr;
  logic [63:0]   b_wdata, b_rdata;
  // entry port
  logic          e_we;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [166:0]  e_wdata, e_rdata;

  // page slot in the upper address bits, so the depth is a full power of two
  eisbp_bloom_mem #(.Depth(2**BAW), .AW(BAW)) u_bloom (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata));
  eisbp_entry_mem #(.Depth(2**EAW), .AW(EAW)) u_ent (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata), .raddr(e_raddr), .rdata(e_rdata));

  // slice addressing from the shifting hash register
  logic [WW-1:0] word_sel;
  logic [5:0]    bit_sel;
  assign word_sel = slice_r[6 +: WW];
  assign bit_sel  = slice_r[5:0];

  logic [PW-1:0] old_pg;
  logic          old_full;
  logic [64:0]   lim_sum;
  logic [63:0]   limit;
  assign old_pg   = oldest_r;
  assign old_full = fill_r[old_pg] >= FW'(ENTRIES_PER_PAGE);
  assign lim_sum  = {1'b0, ftime_r[old_pg]} + {33'd0, page_life_r};
  assign limit    = lim_sum[64] ? '1 : lim_sum[63:0];

  // newest page in use and the slot a fresh page would take
  logic [PW:0]   open_sum, last_sum;
  logic [PW-1:0] open_pg, last_pg;
  logic          need_open, ring_full;
  assign open_sum  = {1'b0, oldest_r} + (PW+1)'(inuse_r);
  assign last_sum  = open_sum - (PW+1)'(1);
  assign open_pg   = (open_sum >= (PW+1)'(PAGE_SLOTS)) ?
                     PW'(open_sum - (PW+1)'(PAGE_SLOTS)) : open_sum[PW-1:0];
  assign last_pg   = (last_sum >= (PW+1)'(PAGE_SLOTS)) ?
                     PW'(last_sum - (PW+1)'(PAGE_SLOTS)) : last_sum[PW-1:0];
  assign need_open = (inuse_r == '0) || (fill_r[last_pg] >= FW'(ENTRIES_PER_PAGE));
  assign ring_full = inuse_r >= CW'(PAGE_SLOTS);

  logic ent_match;
  assign ent_match = (e_rdata[164:160] == len_r) && (e_rdata[159:0] == id_r);

  logic [PW:0] ring_sum;
  logic [PW-1:0] pg_after;
  assign ring_sum = {1'b0, oldest_r} + (PW+1)'(pcnt_r);
  assign pg_after = (ring_sum >= (PW+1)'(PAGE_SLOTS)) ?
                    PW'(ring_sum - (PW+1)'(PAGE_SLOTS)) : ring_sum[PW-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser) state_nxt = S_LK_PAGE;
          else if (need_open) state_nxt = ring_full ? S_DONE : S_CLR;
          else state_nxt = S_ADD_BLOOM_RD;
        end
      end
      S_CLR: if (clr_r == WW'(WPP-1)) state_nxt = S_ADD_BLOOM_RD;
      S_ADD_BLOOM_RD:   state_nxt = S_ADD_BLOOM_WAIT;
      S_ADD_BLOOM_WAIT: state_nxt = S_ADD_BLOOM_WR;
      S_ADD_BLOOM_WR:
        state_nxt = (hidx_r == HW'(HASH_FUNCS-1)) ? S_ADD_STORE : S_ADD_BLOOM_RD;
      S_ADD_STORE:      state_nxt = S_EXPIRE;
      S_EXPIRE:
        if (!(inuse_r != '0 && old_full && old_pg != newest_r && limit < now_r))
          state_nxt = S_DONE;
      S_LK_PAGE:        state_nxt = (pcnt_r >= inuse_r) ? S_DONE : S_LK_BLOOM_RD;
      S_LK_BLOOM_RD:    state_nxt = S_LK_BLOOM_WAIT;
      S_LK_BLOOM_WAIT:  state_nxt = S_LK_BLOOM_CHK;
      S_LK_BLOOM_CHK:
        if (!b_rdata[bit_sel]) state_nxt = S_LK_PAGE;
        else if (hidx_r == HW'(HASH_FUNCS-1)) state_nxt = S_LK_ENT_RD;
        else state_nxt = S_LK_BLOOM_RD;
      S_LK_ENT_RD:      state_nxt = (ent_r >= fill_r[pg_r]) ? S_LK_PAGE : S_LK_ENT_WAIT;
      S_LK_ENT_WAIT:    state_nxt = S_LK_ENT_CHK;
      S_LK_ENT_CHK:     state_nxt = ent_match ? S_DONE : S_LK_ENT_RD;
      S_DONE:           if (!out_valid_r) state_nxt = S_IDLE;
      default:          state_nxt = S_IDLE;
    endcase
  end

  // memory port drive; an add reads the newest page, a lookup the page being scanned
  always_comb begin
    b_we    = 1'b0;
    b_waddr = {newest_r, word_sel};
    b_wdata = b_rdata | (64'd1 << bit_sel);
    b_raddr = {mode_r ? pg_r : newest_r, word_sel};
    if (state_r == S_CLR) begin
      b_we    = 1'b1;
      b_waddr = {newest_r, clr_r};
      b_wdata = '0;
    end else if (state_r == S_ADD_BLOOM_WR) begin
      b_we = 1'b1;
    end
    e_we    = (state_r == S_ADD_STORE);
    e_waddr = {newest_r, fill_r[newest_r][EW-1:0]};
    e_wdata = {kind_r, len_r, id_r};
    e_raddr = {pg_r, ent_r[EW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      page_life_r <= '0;
      oldest_r    <= '0;
      inuse_r     <= '0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < PAGE_SLOTS; p++) begin
        fill_r[p]  <= '0;
        ftime_r[p] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) page_life_r <= cfg_data;
          if (in_tvalid) begin
            mode_r    <= in_tuser;
            len_r     <= in_tdata[4:0];
            id_r      <= eisbp_mask_id(in_tdata[4:0], in_tdata[164:5]);
            hash_r    <= in_tdata[228:165];
            slice_r   <= in_tdata[228:165];
            kind_r    <= in_tdata[230:229];
            now_r     <= in_tdata[294:231];
            hidx_r    <= '0;
            clr_r     <= '0;
            expired_r <= '0;
            pcnt_r    <= '0;
            if (!in_tuser) begin
              // pick or open the newest page
              if (need_open) begin
                if (ring_full) begin
                  out_data_r  <= {22'd0, StAddFail};
                  out_valid_r <= 1'b1;
                end else begin
                  newest_r         <= open_pg;
                  fill_r[open_pg]  <= '0;
                  ftime_r[open_pg] <= '0;
                  inuse_r          <= inuse_r + 1'b1;
                end
              end else begin
                newest_r <= last_pg;
              end
            end
          end
        end
        S_CLR: clr_r <= clr_r + 1'b1;
        S_ADD_BLOOM_WR: begin
          hidx_r  <= hidx_r + 1'b1;
          slice_r <= slice_r >> SliceShift;
        end
        S_ADD_STORE: begin
          out_data_r <= {6'd0, 3'd0, kind_r, 8'(fill_r[newest_r]), 3'(newest_r), StAdded};
          fill_r[newest_r] <= fill_r[newest_r] + 1'b1;
          if (fill_r[newest_r] + 1'b1 >= FW'(ENTRIES_PER_PAGE)) ftime_r[newest_r] <= now_r;
        end
        S_EXPIRE: begin
          if (inuse_r != '0 && old_full && old_pg != newest_r && limit < now_r) begin
            fill_r[old_pg] <= '0;
            oldest_r  <= (oldest_r == PW'(PAGE_SLOTS-1)) ? '0 : oldest_r + 1'b1;
            inuse_r   <= inuse_r - 1'b1;
            expired_r <= expired_r + 1'b1;
          end else begin
            out_data_r[17:15] <= expired_r;
            out_valid_r <= 1'b1;
          end
        end
        S_LK_PAGE: begin
          pg_r    <= pg_after;
          slice_r <= hash_r;
          hidx_r  <= '0;
          ent_r   <= '0;
          pcnt_r  <= pcnt_r + 1'b1;
          if (pcnt_r >= inuse_r) begin
            out_data_r  <= {22'd0, StNotFound};
            out_valid_r <= 1'b1;
          end
        end
        S_LK_BLOOM_CHK: begin
          hidx_r  <= hidx_r + 1'b1;
          slice_r <= slice_r >> SliceShift;
        end
        S_LK_ENT_CHK: begin
          if (ent_match) begin
            out_data_r  <= {6'd0, 3'd0, e_rdata[166:165], 8'(ent_r), 3'(pg_r), StFound};
            out_valid_r <= 1'b1;
          end
          ent_r <= ent_r + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/eisbp_entry_mem.sv =====
module eisbp_entry_mem #(
  parameter int Depth = 2048,
  parameter int AW    = 11
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  logic [166:0]    wdata,
  input  logic [AW-1:0]   raddr,
  output logic [166:0]    rdata
);
  // id (160), length (5), kind (2)
  logic [166:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/eisbp_bloom_mem.sv =====
module eisbp_bloom_mem #(
  parameter int Depth = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [63:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [63:0]   rdata
);
  logic [63:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== tb/tb_expiring_id_set_bloom_pages.sv =====
`timescale 1ns / 100ps

module tb_expiring_id_set_bloom_pages;
  import eisbp_pkg::*;

  // operation carried on in_tuser
  localparam bit ModeAdd    = 1'b0;
  localparam bit ModeLookup = 1'b1;

  localparam int Slots         = 8;
  localparam int Entries       = 256;
  localparam int WordsPerPage  = 128;
  localparam int MaxCycles     = 40_000_000;

  typedef struct {
    bit        mode;
    bit [4:0]  len;
    bit [63:0] lo;
    bit [63:0] mid;
    bit [31:0] hi;
    bit [63:0] hash;
    bit [1:0]  kind;
    bit [63:0] now;
  } id_request_t;

  typedef struct {
    bit [1:0] status;
    bit [2:0] page_slot;
    bit [7:0] entry_slot;
    bit [1:0] kind;
    bit [2:0] expired;
  } id_result_t;

  // only the bytes below the length count; lengths above 20 keep all 20
  function automatic bit [159:0] significant_bytes(bit [4:0] len, bit [159:0] id);
    bit [159:0] m;
    m = '0;
    for (int b = 0; b < 20; b++) begin
      if (b < len) m[b*8 +: 8] = 8'hff;
    end
    return id & m;
  endfunction

  // tracks the page ring and predicts the status of every transfer
  class id_set_scoreboard;
    bit [63:0]   id_lo[Slots*Entries];
    bit [63:0]   id_mid[Slots*Entries];
    bit [31:0]   id_hi[Slots*Entries];
    bit [4:0]    id_len[Slots*Entries];
    bit [1:0]    id_kind[Slots*Entries];
    bit [63:0]   bloom[Slots*WordsPerPage];
    int unsigned fill[Slots];
    bit [63:0]   full_time[Slots];
    int unsigned oldest;
    int unsigned in_use;
    bit [31:0]   page_life;
    id_result_t  awaited[$];
    int unsigned mismatches;

    function void note_request(id_request_t r);
      id_result_t res;
      bit [159:0] id;
      bit [63:0]  s;
      bit [64:0]  lim;
      int unsigned newest, e, at, slot, hits;
      bit ok;
      res = '{default: 0};
      id = significant_bytes(r.len, {r.hi, r.mid, r.lo});
      if (r.mode == ModeAdd) begin
        newest = (oldest + (in_use != 0 ? in_use - 1 : 0)) % Slots;
        ok = 1'b1;
        if (in_use == 0 || fill[newest] >= Entries) begin
          if (in_use >= Slots) begin
            ok = 1'b0;
          end else begin
            newest = (oldest + in_use) % Slots;
            fill[newest] = 0;
            full_time[newest] = '0;
            for (int w = 0; w < WordsPerPage; w++) bloom[newest*WordsPerPage + w] = '0;
            in_use++;
          end
        end
        if (!ok) begin
          res.status = StAddFail;
        end else begin
          e = fill[newest];
          at = newest * Entries + e;
          {id_hi[at], id_mid[at], id_lo[at]} = id;
          id_len[at] = r.len;
          id_kind[at] = r.kind;
          fill[newest] = e + 1;
          s = r.hash;
          for (int i = 0; i < 6; i++) begin
            bloom[newest*WordsPerPage + s[12:6]] |= 64'd1 << s[5:0];
            s = s >> 10;
          end
          if (fill[newest] >= Entries) full_time[newest] = r.now;
          // free old full pages, never the one just written
          while (in_use > 0) begin
            lim = {1'b0, full_time[oldest]} + {33'd0, page_life};
            if (lim[64]) lim[63:0] = '1;
            if (fill[oldest] < Entries || oldest == newest || !(lim[63:0] < r.now)) break;
            fill[oldest] = 0;
            oldest = (oldest + 1) % Slots;
            in_use--;
            res.expired++;
          end
          res.status = StAdded;
          res.page_slot = newest[2:0];
          res.entry_slot = e[7:0];
          res.kind = r.kind;
        end
      end else begin
        res.status = StNotFound;
        for (int p = 0; p < in_use && res.status == StNotFound; p++) begin
          slot = (oldest + p) % Slots;
          s = r.hash;
          hits = 0;
          for (int i = 0; i < 6; i++) begin
            if (bloom[slot*WordsPerPage + s[12:6]][s[5:0]]) hits++;
            s = s >> 10;
          end
          if (hits < 6) continue;
          for (int j = 0; j < fill[slot] && j < Entries; j++) begin
            at = slot * Entries + j;
            if (id_len[at] == r.len && {id_hi[at], id_mid[at], id_lo[at]} == id) begin
              res.status = StFound;
              res.page_slot = slot[2:0];
              res.entry_slot = j[7:0];
              res.kind = id_kind[at];
              break;
            end
          end
        end
      end
      awaited.push_back(res);
    endfunction

    function void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_result(bit [23:0] d);
      id_result_t x;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result expected none actual %h", $time, d);
        mismatches++;
        return;
      end
      x = awaited.pop_front();
      check_field("status", x.status, d[1:0]);
      check_field("page_slot", x.page_slot, d[4:2]);
      check_field("entry_slot", x.entry_slot, d[12:5]);
      check_field("found_kind", x.kind, d[14:13]);
      check_field("pages_expired", x.expired, d[17:15]);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [295:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;

  id_set_scoreboard sb;
  id_request_t      added_ids[$];   // identifiers worth looking up again
  bit [63:0]        clock_us;       // running time stamp for adds
  bit               no_idle;        // stretch with back-to-back transfers
  int unsigned      cycles = 0;

  expiring_id_set_bloom_pages dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // hash over the significant bytes, so equal identifiers hash alike
  function automatic bit [63:0] id_hash_of(id_request_t r);
    bit [159:0] id;
    bit [63:0]  h;
    id = significant_bytes(r.len, {r.hi, r.mid, r.lo});
    h = id[63:0] * 64'h9E3779B97F4A7C15 ^ id[127:64] * 64'hC2B2AE3D27D4EB4F ^
        {32'd0, id[159:128]} * 64'h165667B19E3779F9 ^ {59'd0, r.len};
    h = h ^ (h >> 29);
    h = h * 64'hBF58476D1CE4E5B9;
    return h ^ (h >> 32);
  endfunction

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic id_request_t fresh_id(bit mode, bit [4:0] len);
    id_request_t r;
    r.mode = mode;
    r.len = len;
    r.lo = rand64();
    r.mid = rand64();
    r.hi = $urandom;
    r.kind = 2'($urandom_range(0, 3));
    r.now = clock_us;
    r.hash = id_hash_of(r);
    return r;
  endfunction

  // same identifier, with fresh junk in the bytes beyond its length
  function automatic id_request_t lookup_of(id_request_t a);
    id_request_t r;
    bit [159:0] keep, junk;
    r = a;
    r.mode = ModeLookup;
    keep = significant_bytes(a.len, '1);
    junk = {$urandom, rand64(), rand64()};
    {r.hi, r.mid, r.lo} = ({a.hi, a.mid, a.lo} & keep) | (junk & ~keep);
    r.kind = 2'($urandom_range(0, 3));
    r.now = rand64();
    return r;
  endfunction

  // one input transfer; valid stays high when the next one follows at once
  task automatic send_request(id_request_t r);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {1'b0, r.now, r.kind, r.hash, r.hi, r.mid, r.lo, r.len};
    in_tuser <= r.mode;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
    if (r.mode == ModeAdd) begin
      added_ids.push_back(r);
      if (added_ids.size() > 400) added_ids.delete($urandom_range(0, 399));
    end
  endtask

  task automatic write_page_life(bit [31:0] v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.page_life = v;
  endtask

  // wait for every result to be checked, then idle with valid low before the next phase
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic random_request();
    id_request_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      r = fresh_id(ModeAdd, ($urandom_range(0, 9) == 0) ? 5'($urandom_range(21, 31))
                                                         : 5'($urandom_range(0, 20)));
    end else if (pick < 90 && added_ids.size() > 0) begin
      r = lookup_of(added_ids[$urandom_range(0, added_ids.size() - 1)]);
      if ($urandom_range(0, 9) == 0) r.hash = rand64();   // stray hash, bloom miss
    end else begin
      r = fresh_id(ModeLookup, 5'($urandom_range(0, 31)));
      r.now = rand64();
    end
    send_request(r);
    clock_us += $urandom_range(0, 40);
  endtask

  // receiving side: random stalls, each result transfer checked in order
  initial begin
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
    end
  end

  initial begin
    id_request_t r, a;
    bit [31:0] lives[4];
    sb = new();
    clock_us = 64'd1000;
    no_idle = 1'b0;
    lives = '{32'd0, 32'd37, 32'hFFFF_FFFF, 32'd5};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_page_life(32'd0);

    // directed: empty lookup, length extremes, kinds, junk beyond length
    r = fresh_id(ModeLookup, 5'd20);
    send_request(r);
    r = fresh_id(ModeAdd, 5'd0);
    r.kind = 2'd0;
    send_request(r);
    r = fresh_id(ModeAdd, 5'd20);
    r.lo = '1; r.mid = '1; r.hi = '1; r.kind = 2'd3; r.now = '1;
    r.hash = id_hash_of(r);
    send_request(r);
    r = fresh_id(ModeAdd, 5'd31);
    r.kind = 2'd1;
    send_request(r);
    a = r;
    r = fresh_id(ModeAdd, 5'd7);
    r.kind = 2'd2;
    send_request(r);
    r = fresh_id(ModeAdd, 5'd17);
    send_request(r);
    send_request(r);                       // duplicate: first copy wins
    for (int k = 0; k < added_ids.size(); k++) send_request(lookup_of(added_ids[k]));
    r = lookup_of(a);
    r.len = 5'd20;                         // same bytes, other length value
    r.hash = id_hash_of(r);
    send_request(r);
    r.len = 5'd25;
    r.hash = id_hash_of(r);
    send_request(r);
    r = lookup_of(added_ids[3]);
    r.len = 5'd20;
    r.hash = id_hash_of(r);
    send_request(r);
    r = fresh_id(ModeLookup, 5'd0);        // empty identifier, junk bytes
    r.lo = '1; r.mid = '1; r.hi = '1;
    send_request(r);
    settle();

    // random phases under several lifetimes; the longest one runs near the top
    // of time, so the expiry sum saturates
    for (int ph = 0; ph < 4; ph++) begin
      write_page_life(lives[ph]);
      if (ph == 2) clock_us = 64'hFFFF_FFFF_F000_0000;
      no_idle = (ph == 2);
      repeat (300) random_request();
      settle();
    end
    no_idle = 1'b0;

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
